@@ hw/rtl/sih_pkg.sv @@
// Shared types and constants for the sub-interrupt handler table.
// Used by sih_seq and sub_interrupt_handler_table; no dependencies.
`default_nettype none

package sih_pkg;

  localparam int SLOTS_DEF   = 16;
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = 5;
  localparam int INTR_W      = 8;
  localparam int SUB_W       = 8;
  localparam int ADDR_W      = 32;
  localparam int ARG_W       = 32;
  // slot word, high to low: intr, sub, handler, cookie
  localparam int SLOT_W      = INTR_W + SUB_W + ADDR_W + ARG_W;

  typedef enum logic [1:0] {
    CMD_REGISTER = 2'd0,
    CMD_RELEASE  = 2'd1,
    CMD_ENABLE   = 2'd2,
    CMD_DISPATCH = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_SLOT = 2'd1,
    ST_NOT_REG = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_SCAN,
    SEQ_FLUSH,
    SEQ_FINISH
  } seq_state_t;

  typedef struct packed {
    status_t           status;
    logic              is_handler;
    logic [SUB_W-1:0]  sub;
    logic [ADDR_W-1:0] handler;
    logic [ARG_W-1:0]  arg;
    logic [CNT_W-1:0]  cnt;
    logic              last;
  } res_t;

  function automatic res_t res_empty(status_t st);
    res_t r;
    r            = '0;
    r.status     = st;
    r.last       = 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sih_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module sih_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/sih_seq.sv @@
// Scan sequencer: walks the slot RAM, keeps valid/enable bits, drives results.
// Depends on sih_pkg; drives the port of one sih_ram instance.
`default_nettype none

module sih_seq #(
  parameter int SLOTS = sih_pkg::SLOTS_DEF,
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire sih_pkg::cmd_t                 in_cmd,
  input  wire logic [sih_pkg::INTR_W-1:0]    in_intr,
  input  wire logic [sih_pkg::SUB_W-1:0]     in_sub,
  input  wire logic [sih_pkg::ADDR_W-1:0]    in_hnd,
  input  wire logic [sih_pkg::ARG_W-1:0]     in_arg,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output sih_pkg::res_t                      out_res,
  output logic                               ram_we,
  output logic [IW-1:0]                      ram_waddr,
  output logic [sih_pkg::SLOT_W-1:0]         ram_wdata,
  output logic [IW-1:0]                      ram_raddr,
  input  wire logic [sih_pkg::SLOT_W-1:0]    ram_rdata
);

  import sih_pkg::*;

  seq_state_t        state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [INTR_W-1:0] intr_r, intr_nxt;
  logic [SUB_W-1:0]  sub_r, sub_nxt;
  logic [ADDR_W-1:0] hnd_r, hnd_nxt;
  logic [ARG_W-1:0]  arg_r, arg_nxt;
  logic [IW-1:0]     chk_idx_r, chk_idx_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              hold_v_r, hold_v_nxt;
  res_t              hold_r, hold_nxt;
  logic              match_v_r, match_v_nxt;
  logic [IW-1:0]     match_idx_r, match_idx_nxt;
  logic              free_v_r, free_v_nxt;
  logic [IW-1:0]     free_idx_r, free_idx_nxt;
  logic [SLOTS-1:0]  valid_r, valid_nxt;
  logic [SLOTS-1:0]  en_r, en_nxt;
  logic              out_v_r, out_v_nxt;
  res_t              out_r, out_nxt;

  logic [INTR_W-1:0] rd_intr;
  logic [SUB_W-1:0]  rd_sub;
  logic [ADDR_W-1:0] rd_hnd;
  logic [ARG_W-1:0]  rd_arg;
  logic              cur_valid, cur_en, key_hit, disp_hit, scan_end, out_free, stall;
  logic [IW-1:0]     next_idx, target;

  assign rd_arg  = ram_rdata[ARG_W-1:0];
  assign rd_hnd  = ram_rdata[ARG_W +: ADDR_W];
  assign rd_sub  = ram_rdata[ARG_W + ADDR_W +: SUB_W];
  assign rd_intr = ram_rdata[ARG_W + ADDR_W + SUB_W +: INTR_W];

  assign cur_valid = valid_r[chk_idx_r];
  assign cur_en    = en_r[chk_idx_r];
  assign key_hit   = cur_valid && (rd_intr == intr_r) && (rd_sub == sub_r);
  assign disp_hit  = cur_valid && cur_en && (rd_intr == intr_r) &&
                     (cnt_r != CNT_W'(MAX_RESULTS));
  assign scan_end  = (chk_idx_r == IW'(SLOTS - 1));
  assign out_free  = !out_v_r || out_ready;
  assign next_idx  = chk_idx_r + IW'(1);
  assign target    = match_v_r ? match_idx_r : free_idx_r;
  // a dispatch hit must push the held result out before it can be replaced
  assign stall     = (cmd_r == CMD_DISPATCH) && disp_hit && hold_v_r && !out_free;

  assign out_valid = out_v_r;
  assign out_res   = out_r;
  assign ram_waddr = target;
  assign ram_wdata = {intr_r, sub_r, hnd_r, arg_r};

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    intr_nxt      = intr_r;
    sub_nxt       = sub_r;
    hnd_nxt       = hnd_r;
    arg_nxt       = arg_r;
    chk_idx_nxt   = chk_idx_r;
    cnt_nxt       = cnt_r;
    hold_v_nxt    = hold_v_r;
    hold_nxt      = hold_r;
    match_v_nxt   = match_v_r;
    match_idx_nxt = match_idx_r;
    free_v_nxt    = free_v_r;
    free_idx_nxt  = free_idx_r;
    valid_nxt     = valid_r;
    en_nxt        = en_r;
    out_v_nxt     = out_v_r && !out_ready;
    out_nxt       = out_r;
    in_ready      = 1'b0;
    ram_we        = 1'b0;
    ram_raddr     = chk_idx_r;

    case (state_r)
      SEQ_IDLE: begin
        in_ready  = 1'b1;
        ram_raddr = '0;
        if (in_valid) begin
          cmd_nxt     = in_cmd;
          intr_nxt    = in_intr;
          sub_nxt     = in_sub;
          hnd_nxt     = in_hnd;
          arg_nxt     = in_arg;
          chk_idx_nxt = '0;
          cnt_nxt     = '0;
          hold_v_nxt  = 1'b0;
          match_v_nxt = 1'b0;
          free_v_nxt  = 1'b0;
          state_nxt   = SEQ_SCAN;
        end
      end

      SEQ_SCAN: begin
        if (stall) begin
          // re-read the same slot so its data is still there next cycle
          ram_raddr = chk_idx_r;
        end else begin
          ram_raddr   = next_idx;
          chk_idx_nxt = next_idx;
          if (cmd_r == CMD_DISPATCH) begin
            if (disp_hit) begin
              if (hold_v_r) begin
                out_v_nxt = 1'b1;
                out_nxt   = hold_r;
              end
              hold_v_nxt          = 1'b1;
              hold_nxt.status     = ST_OK;
              hold_nxt.is_handler = 1'b1;
              hold_nxt.sub        = rd_sub;
              hold_nxt.handler    = rd_hnd;
              hold_nxt.arg        = rd_arg;
              hold_nxt.cnt        = cnt_r + CNT_W'(1);
              hold_nxt.last       = 1'b0;
              cnt_nxt             = cnt_r + CNT_W'(1);
            end
          end else begin
            if (key_hit && !match_v_r) begin
              match_v_nxt   = 1'b1;
              match_idx_nxt = chk_idx_r;
            end
            if (!cur_valid && !free_v_r) begin
              free_v_nxt   = 1'b1;
              free_idx_nxt = chk_idx_r;
            end
          end
          if (scan_end) begin
            state_nxt = (cmd_r == CMD_DISPATCH) ? SEQ_FLUSH : SEQ_FINISH;
          end
        end
      end

      SEQ_FLUSH: begin
        if (out_free) begin
          out_v_nxt = 1'b1;
          if (hold_v_r) begin
            out_nxt      = hold_r;
            out_nxt.last = 1'b1;
          end else begin
            out_nxt = res_empty(ST_OK);
          end
          hold_v_nxt = 1'b0;
          state_nxt  = SEQ_IDLE;
        end
      end

      SEQ_FINISH: begin
        // the slot update lands before the next scan can issue a read
        if (out_free) begin
          out_v_nxt = 1'b1;
          state_nxt = SEQ_IDLE;
          case (cmd_r)
            CMD_REGISTER: begin
              if (match_v_r || free_v_r) begin
                ram_we            = 1'b1;
                valid_nxt[target] = 1'b1;
                out_nxt           = res_empty(ST_OK);
              end else begin
                out_nxt = res_empty(ST_NO_SLOT);
              end
            end
            CMD_RELEASE: begin
              if (match_v_r) begin
                valid_nxt[match_idx_r] = 1'b0;
                en_nxt[match_idx_r]    = 1'b0;
                out_nxt                = res_empty(ST_OK);
              end else begin
                out_nxt = res_empty(ST_NOT_REG);
              end
            end
            CMD_ENABLE: begin
              if (match_v_r) begin
                en_nxt[match_idx_r] = 1'b1;
                out_nxt             = res_empty(ST_OK);
              end else begin
                out_nxt = res_empty(ST_NOT_REG);
              end
            end
            default: begin
              out_nxt = res_empty(ST_OK);
            end
          endcase
        end
      end

      default: begin
        state_nxt = SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= SEQ_IDLE;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      valid_r  <= '0;
      en_r     <= '0;
    end else begin
      state_r  <= state_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
      valid_r  <= valid_nxt;
      en_r     <= en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    intr_r      <= intr_nxt;
    sub_r       <= sub_nxt;
    hnd_r       <= hnd_nxt;
    arg_r       <= arg_nxt;
    chk_idx_r   <= chk_idx_nxt;
    cnt_r       <= cnt_nxt;
    hold_r      <= hold_nxt;
    match_v_r   <= match_v_nxt;
    match_idx_r <= match_idx_nxt;
    free_v_r    <= free_v_nxt;
    free_idx_r  <= free_idx_nxt;
    out_r       <= out_nxt;
  end

endmodule

`default_nettype wire

@@ hw/rtl/sub_interrupt_handler_table.sv @@
// Sub-interrupt handler table, top level. Depends on sih_pkg, sih_seq, sih_ram.
// Every request, when the result side keeps up, is accepted, then scanned as the
// sequencer reads the slot RAM slot by slot, then finished.
// A dispatch emits up to 16 results; a stalled result channel holds the scan.
// Reset (rst_n low, synchronous) clears all valid and enable bits;
// slot RAM contents are not cleared and are only read behind a valid bit.
`default_nettype none

module sub_interrupt_handler_table #(
  parameter int SLOTS = sih_pkg::SLOTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [79:0] in_tdata,   // intr_number, sub_number, handler_address, handler_arg
  input  wire logic [1:0]  in_tuser,   // command
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata,  // out_sub, out_handler, out_arg, ran_count, zero pad
  output logic [2:0]       out_tuser,  // status, is_handler
  output logic             out_tlast   // last
);

  import sih_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  res_t              res;
  logic              ram_we;
  logic [IW-1:0]     ram_waddr, ram_raddr;
  logic [SLOT_W-1:0] ram_wdata, ram_rdata;

  sih_seq #(
    .SLOTS(SLOTS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (cmd_t'(in_tuser)),
    .in_intr   (in_tdata[7:0]),
    .in_sub    (in_tdata[15:8]),
    .in_hnd    (in_tdata[47:16]),
    .in_arg    (in_tdata[79:48]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  sih_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_tdata = {3'b000, res.cnt, res.arg, res.handler, res.sub};
  assign out_tuser = {res.is_handler, res.status};
  assign out_tlast = res.last;

endmodule

`default_nettype wire
